### src/szrd_pkg.sv
// ----------------------------------------------------------------------------
// szrd_pkg
// Shared types for the six-bit zero-run decoder: one result word and the
// bundle of up to two results that a single input byte yields.
// ----------------------------------------------------------------------------
package szrd_pkg;

   localparam int CODE_W  = 6;
   localparam int BYTE_W  = 8;
   localparam int STORE_W = 14;
   localparam int HELD_W  = 4;

   // one value/count run
   typedef struct packed {
      logic [CODE_W-1:0] value;
      logic [CODE_W-1:0] count;
      logic              last_of_item;
   } result_type;

   // results caused by one input byte, compacted into r0 then r1
   typedef struct packed {
      logic [1:0] num;
      result_type r0;
      result_type r1;
   } dec_bundle_type;

endpackage

### src/szrd_decode.sv
// ----------------------------------------------------------------------------
// szrd_decode
// Bit accumulator and code interpreter. From the registered input byte and
// the held state it forms up to two codes, interprets them as headers or
// literals, and updates the state when the byte is consumed.
// ----------------------------------------------------------------------------
module szrd_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic [szrd_pkg::BYTE_W-1:0]      byte_value,
   input  logic                             from_tail,
   output szrd_pkg::dec_bundle_type         bundle
);

   localparam int CW = szrd_pkg::CODE_W;
   localparam int SW = szrd_pkg::STORE_W;
   localparam int HW = szrd_pkg::HELD_W;

   logic [SW-1:0] bit_store_ff, bit_store_in;
   logic [HW-1:0] bits_held_ff, bits_held_in;
   logic [CW-1:0] lits_left_ff, lits_left_in;

   // one code step: literal when literals are pending, else a header
   typedef struct packed {
      logic          emit;
      logic [CW-1:0] value;
      logic [CW-1:0] count;
      logic [CW-1:0] lits;
   } step_type;

   function automatic step_type take_code(input logic [CW-1:0] code,
                                          input logic [CW-1:0] lits);
      step_type s;
      s.emit  = 1'b0;
      s.value = '0;
      s.count = '0;
      s.lits  = lits;
      if (lits != '0) begin
         s.emit  = 1'b1;
         s.value = code;
         s.count = CW'(1);
         s.lits  = lits - CW'(1);
      end else if (code[CW-1]) begin
         s.lits  = {1'b0, code[CW-2:0]} + CW'(1);
      end else begin
         s.emit  = 1'b1;
         s.count = code + CW'(1);
      end
      return s;
   endfunction

   logic [2:0]    held;
   logic [SW-1:0] merged;
   logic          two_codes;
   logic [CW-1:0] code0, code1;
   step_type      st0, st1;
   szrd_pkg::result_type res0, res1;

   // clamp held count and merge the new byte above the held bits
   always_comb begin
      held      = (bits_held_ff > HW'(5)) ? 3'd5 : bits_held_ff[2:0];
      merged    = bit_store_ff | ({{(SW-szrd_pkg::BYTE_W){1'b0}}, byte_value} << held);
      two_codes = !from_tail && (held >= 3'd4);
      code0     = from_tail ? byte_value[CW-1:0] : merged[CW-1:0];
      code1     = merged[2*CW-1:CW];
   end

   // interpret codes in order
   always_comb begin
      st0 = take_code(code0, lits_left_ff);
      st1 = take_code(code1, st0.lits);
   end

   // compact results and flag the final one
   always_comb begin
      res0 = '{value: st0.value, count: st0.count, last_of_item: 1'b0};
      res1 = '{value: st1.value, count: st1.count, last_of_item: 1'b1};
      bundle.r1 = res1;
      if (st0.emit && two_codes && st1.emit) begin
         bundle.num = 2'd2;
         bundle.r0  = res0;
      end else if (st0.emit) begin
         bundle.num = 2'd1;
         bundle.r0  = '{value: st0.value, count: st0.count, last_of_item: 1'b1};
      end else if (two_codes && st1.emit) begin
         bundle.num = 2'd1;
         bundle.r0  = res1;
      end else begin
         bundle.num = 2'd0;
         bundle.r0  = res0;
      end
   end

   // next state
   always_comb begin
      bit_store_in = bit_store_ff;
      bits_held_in = bits_held_ff;
      lits_left_in = lits_left_ff;
      if (fire) begin
         if (from_tail) begin
            lits_left_in = st0.lits;
         end else if (two_codes) begin
            bit_store_in = merged >> (2*CW);
            bits_held_in = {1'b0, held} - HW'(4);
            lits_left_in = st1.lits;
         end else begin
            bit_store_in = merged >> CW;
            bits_held_in = {1'b0, held} + HW'(2);
            lits_left_in = st0.lits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_store_ff <= '0;
         bits_held_ff <= '0;
         lits_left_ff <= '0;
      end else begin
         bit_store_ff <= bit_store_in;
         bits_held_ff <= bits_held_in;
         lits_left_ff <= lits_left_in;
      end
   end

endmodule

### src/szrd_out_buf.sv
// ----------------------------------------------------------------------------
// szrd_out_buf
// Two-slot result register. Takes all results of one byte at once and
// hands them out one word per cycle on the result channel unless stalled.
// ----------------------------------------------------------------------------
module szrd_out_buf (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  szrd_pkg::dec_bundle_type            bundle,
   output logic                                free,
   output logic [1:0]                          fill,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [szrd_pkg::CODE_W-1:0]         rsp_value,
   output logic [szrd_pkg::CODE_W-1:0]         rsp_count,
   output logic                                rsp_last_of_item
);

   szrd_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 pop;

   // space check: empty, or last word leaving now
   always_comb begin
      pop  = rsp_valid && !rsp_stall;
      free = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   end

   // slot update
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         slot0_in = bundle.r0;
         slot1_in = bundle.r1;
         cnt_in   = bundle.num;
      end else if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign fill             = cnt_ff;
   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_value        = slot0_ff.value;
   assign rsp_count        = slot0_ff.count;
   assign rsp_last_of_item = slot0_ff.last_of_item;

endmodule

### src/six_bit_zero_run_decoder_core.sv
// ----------------------------------------------------------------------------
// six_bit_zero_run_decoder_core
// Decodes compressed bytes into value/count runs of the output stream.
// ----------------------------------------------------------------------------
// Each accepted byte is registered, then decoded together with the held
// bit accumulator and literal count, and its zero, one or two result words
// are loaded together into a two-slot result register. A byte that yields at
// most one word is taken every cycle while the receiver does not stall; a
// byte that yields two words holds the input while its first word is sent,
// since the result port sends one word per cycle.
// ----------------------------------------------------------------------------
module six_bit_zero_run_decoder_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [szrd_pkg::BYTE_W-1:0]      req_byte_value,
   input  logic                             req_from_tail,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [szrd_pkg::CODE_W-1:0]      rsp_value,
   output logic [szrd_pkg::CODE_W-1:0]      rsp_count,
   output logic                             rsp_last_of_item
);

   logic                          in_valid_ff, in_valid_in;
   logic [szrd_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_tail_ff;
   logic                          free, fire, accept;
   logic [1:0]                    fill;
   szrd_pkg::dec_bundle_type      bundle;

   // input register handshake
   always_comb begin
      fire        = in_valid_ff && free;
      req_stall   = in_valid_ff && !fire;
      accept      = req_valid && !req_stall;
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff <= req_byte_value;
         in_tail_ff <= req_from_tail;
      end
   end

   szrd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .byte_value (in_byte_ff),
      .from_tail  (in_tail_ff),
      .bundle     (bundle)
   );

   szrd_out_buf u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .load             (fire),
      .bundle           (bundle),
      .free             (free),
      .fill             (fill),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_count        (rsp_count),
      .rsp_last_of_item (rsp_last_of_item)
   );

`ifndef SYNTHESIS
   // result buffer never holds more than two words
   assert property (@(posedge clock) disable iff (reset) fill != 2'd3)
      else $error("result buffer overfilled");

   // every run carries a count of 1 to 32
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count != '0 && rsp_count <= 6'd32))
      else $error("run count out of range");

   // a held byte that is not decoded stays held
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("input byte dropped");

   // a second word only follows a word that is not last of its byte
   assert property (@(posedge clock) disable iff (reset)
      (fill == 2'd2) |-> !rsp_last_of_item)
      else $error("last flag on first of two words");
`endif

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the six-bit zero-run decoder core.
// ----------------------------------------------------------------------------
// Drives compressed bytes (packed stream and direct tail) through a valid/stall
// channel and checks every value/count run word that comes back. A scoreboard
// object tracks its own bit accumulator and literal count and queues the run
// words that each accepted byte yields. Traffic runs in three phases with
// different idle rates on both sides, plus one long receiver hold-off per
// phase and a full drain in the middle of the run.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       SRC_PACKED = 1'b0;
   localparam logic       SRC_TAIL   = 1'b1;
   localparam logic [5:0] LIT_FLAG   = 6'h20;
   localparam logic [5:0] LEN_MASK   = 6'h1F;
   localparam int         MAX_HELD   = 5;
   localparam int         PHASE_WORDS    = 440;
   localparam int         LONG_HOLD      = 300;
   localparam int         MAX_GAP        = 40;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 8;

   // {from_tail, byte}: header/literal/zero-run extremes, tail bytes with
   // packed bits held, literals crossing sources, two-code packed bytes
   localparam logic [8:0] DIRECTED [20] = '{
      9'h100, 9'h11F, 9'h1E0, 9'h1FF, 9'h020, 9'h0FF, 9'h0AA, 9'h155,
      9'h015, 9'h101, 9'h080, 9'h0FF, 9'h1C0, 9'h000, 9'h001, 9'h13F,
      9'h0FF, 9'h07E, 9'h19C, 9'h000
   };

   // Predicts the run words of each accepted byte and checks them in order
   class zero_run_board;
      logic [13:0] acc_bits;
      logic [3:0]  acc_held;
      logic [5:0]  lits_owed;
      szrd_pkg::result_type  expected_runs[$];
      szrd_pkg::result_type  byte_runs[$];
      int          errors;

      function new();
         acc_bits  = '0;
         acc_held  = '0;
         lits_owed = '0;
         errors    = 0;
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction

      // one code: literal while owed, else header
      function void take_code(logic [5:0] code);
         szrd_pkg::result_type r;
         r.last_of_item = 1'b0;
         if (lits_owed != 0) begin
            lits_owed = lits_owed - 6'd1;
            r.value   = code;
            r.count   = 6'd1;
            byte_runs.push_back(r);
         end else if ((code & LIT_FLAG) != 0) begin
            lits_owed = (code & LEN_MASK) + 6'd1;
         end else begin
            r.value = 6'd0;
            r.count = code + 6'd1;
            byte_runs.push_back(r);
         end
      endfunction

      function void note_byte(logic [7:0] b, logic src);
         int held;
         byte_runs.delete();
         if (src == SRC_TAIL) begin
            take_code(b[5:0]);
         end else begin
            held = (acc_held > MAX_HELD) ? MAX_HELD : int'(acc_held);
            acc_bits = acc_bits | (14'(b) << held);
            held += 8;
            while (held >= 6) begin
               take_code(acc_bits[5:0]);
               acc_bits = acc_bits >> 6;
               held -= 6;
            end
            acc_held = 4'(held);
         end
         if (byte_runs.size() > 0)
            byte_runs[byte_runs.size()-1].last_of_item = 1'b1;
         foreach (byte_runs[i])
            expected_runs.push_back(byte_runs[i]);
      endfunction

      function void check_run(logic [5:0] value, logic [5:0] count, logic last);
         szrd_pkg::result_type e;
         if (expected_runs.size() == 0) begin
            $error("unexpected run word: value %0d count %0d last %0d",
                   value, count, last);
            errors++;
            return;
         end
         e = expected_runs.pop_front();
         if (value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, value);
            errors++;
         end
         if (count !== e.count) begin
            $error("count: expected %0d, got %0d", e.count, count);
            errors++;
         end
         if (last !== e.last_of_item) begin
            $error("last_of_item: expected %0d, got %0d", e.last_of_item, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_value = '0;
   logic       req_from_tail = SRC_PACKED;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [5:0] rsp_value;
   logic [5:0] rsp_count;
   logic       rsp_last_of_item;

   zero_run_board board = new();
   int  send_idle_pct = 0;
   int  rcv_idle_pct  = 0;
   bit  hold_request  = 1'b0;
   int  hold_left     = 0;
   int  quiet_cycles  = 0;

   always #2 clock = ~clock;

   six_bit_zero_run_decoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_value   (req_byte_value),
      .req_from_tail    (req_from_tail),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_count        (rsp_count),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // receiver: random stall, or a long hold-off when asked for one
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   // monitor: note accepted bytes, check accepted run words, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_byte(req_byte_value, req_from_tail);
         if (rsp_valid && !rsp_stall)
            board.check_run(rsp_value, rsp_count, rsp_last_of_item);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[six_bit_zero_run_decoder_core] ERROR");
            $finish;
         end
      end
   end

   // offer one word after a random gap; returns at the accepting edge
   task automatic send_byte(logic [7:0] b, logic src);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_from_tail  <= src;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random();
      logic [7:0] b;
      int         sel;
      b   = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 10)
         b = 8'h00;
      else if (sel < 20)
         b = 8'hFF;
      send_byte(b, ($urandom_range(0, 99) < 25) ? SRC_TAIL : SRC_PACKED);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed words
      foreach (DIRECTED[i])
         send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

      // random phases: sender-light, receiver-light, no idling
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 77 : 0;
         rcv_idle_pct  = (phase == 0) ? 77 : (phase == 1) ? 22 : 0;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i == 100)
               hold_request = 1'b1;
            // sender pauses until every run word is back
            if (phase == 1 && i == 200) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (board.pending() > 0) @(posedge clock);
            end
            send_random();
         end
      end

      // drain and settle
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0)
         $display("[six_bit_zero_run_decoder_core] OK");
      else
         $display("[six_bit_zero_run_decoder_core] ERROR");
      $finish;
   end

endmodule
